>>> hdl/sfpd_pkg.sv
`timescale 1ns / 1ps
package sfpd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam int LEN_W = 6;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_CRC_BAD  = 2'd1;
  localparam logic [1:0] ST_BAD_ID   = 2'd2;
  localparam logic [1:0] ST_BAD_LEN  = 2'd3;

  localparam logic [1:0] REG_SYNC0  = 2'd0;
  localparam logic [1:0] REG_SYNC1  = 2'd1;
  localparam logic [1:0] REG_MSG_ID = 2'd2;
  localparam logic [1:0] REG_EXP_LEN = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       seq;
    logic [LEN_W-1:0] len;
    logic             run;
  } job_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/sfpd_front.sv
`timescale 1ns / 1ps
module sfpd_front import sfpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          push,
  output job_t          push_job,
  input  logic          run_done,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  localparam int RUN_LIMIT = (MAX_PAYLOAD < 32) ? MAX_PAYLOAD : 32;

  typedef enum logic [2:0] {
    PH_HUNT0, PH_HUNT1, PH_ID, PH_LEN, PH_SEQ, PH_SKIP, PH_PAYLOAD, PH_CRC
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        seq_r, seq_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        crclo_r, crclo_nxt;
  logic [8:0]        cnt_r, cnt_nxt;
  logic              pay_pend_r, pay_pend_nxt;
  logic [7:0]        sync0_r, sync1_r, msg_id_r;
  logic [LEN_W-1:0]  exp_len_r;
  logic              accept;
  logic [8:0]        cnt_inc;
  logic [15:0]       crc_upd;

  assign in_ready = !q_full && !(phase_r == PH_PAYLOAD && pay_pend_r);
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = cnt_r + 9'd1;
  assign crc_upd  = crc_feed(crc_r, in_byte);

  always_comb begin
    phase_nxt    = phase_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    seq_nxt      = seq_r;
    crc_nxt      = crc_r;
    crclo_nxt    = crclo_r;
    cnt_nxt      = cnt_r;
    pay_pend_nxt = pay_pend_r;
    push         = 1'b0;
    push_job     = '{status: ST_ACCEPTED, seq: seq_r, len: len_r[LEN_W-1:0], run: 1'b0};
    wr_en        = 1'b0;
    wr_addr      = cnt_r[AW-1:0];
    wr_data      = in_byte;
    if (run_done) begin
      pay_pend_nxt = 1'b0;
    end
    if (accept) begin
      unique case (phase_r)
        PH_HUNT0: begin
          if (in_byte == sync0_r) phase_nxt = PH_HUNT1;
        end
        PH_HUNT1: begin
          if (in_byte == sync1_r) begin
            crc_nxt   = CRC_INIT;
            phase_nxt = PH_ID;
          end else begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_ID: begin
          id_nxt    = in_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt   = in_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          seq_nxt = in_byte;
          crc_nxt = crc_upd;
          cnt_nxt = '0;
          if (id_r == msg_id_r && len_r == {2'b00, exp_len_r} && len_r <= 8'(RUN_LIMIT)) begin
            phase_nxt = (len_r != 8'd0) ? PH_PAYLOAD : PH_CRC;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= ({1'b0, len_r} + 9'd2)) begin
            push            = 1'b1;
            push_job.status = (id_r != msg_id_r) ? ST_BAD_ID : ST_BAD_LEN;
            cnt_nxt         = '0;
            phase_nxt       = PH_HUNT0;
          end
        end
        PH_PAYLOAD: begin
          wr_en   = 1'b1;
          crc_nxt = crc_upd;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= {1'b0, len_r}) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          if (cnt_r == 9'd0) begin
            crclo_nxt = in_byte;
            cnt_nxt   = 9'd1;
          end else begin
            push = 1'b1;
            if ({in_byte, crclo_r} != crc_r) begin
              push_job.status = ST_CRC_BAD;
            end else if (len_r != 8'd0) begin
              push_job.run = 1'b1;
              pay_pend_nxt = 1'b1;
            end
            cnt_nxt   = '0;
            phase_nxt = PH_HUNT0;
          end
        end
        default: phase_nxt = PH_HUNT0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT0;
      id_r       <= '0;
      len_r      <= '0;
      seq_r      <= '0;
      crc_r      <= CRC_INIT;
      crclo_r    <= '0;
      cnt_r      <= '0;
      pay_pend_r <= 1'b0;
      sync0_r    <= 8'hAA;
      sync1_r    <= 8'h55;
      msg_id_r   <= 8'h01;
      exp_len_r  <= LEN_W'(18);
    end else begin
      phase_r    <= phase_nxt;
      id_r       <= id_nxt;
      len_r      <= len_nxt;
      seq_r      <= seq_nxt;
      crc_r      <= crc_nxt;
      crclo_r    <= crclo_nxt;
      cnt_r      <= cnt_nxt;
      pay_pend_r <= pay_pend_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SYNC0:   sync0_r   <= cfg_data;
          REG_SYNC1:   sync1_r   <= cfg_data;
          REG_MSG_ID:  msg_id_r  <= cfg_data;
          REG_EXP_LEN: exp_len_r <= cfg_data[LEN_W-1:0];
          default:     sync0_r   <= sync0_r;
        endcase
      end
    end
  end

  a_no_write_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !pay_pend_r) else $error("payload store written while a run is pending");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("job pushed into a full queue");

endmodule

>>> hdl/sfpd_queue.sv
`timescale 1ns / 1ps
module sfpd_queue import sfpd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("pop from an empty queue");

endmodule

>>> hdl/sfpd_back.sv
`timescale 1ns / 1ps
module sfpd_back import sfpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  job_t          q_job,
  output logic          pop,
  output logic          run_done,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_frame_status,
  output logic [7:0]    out_sequence_res,
  output logic [4:0]    out_byte_index,
  output logic [7:0]    out_payload_byte,
  output logic          out_run_last
);

  typedef enum logic {BK_IDLE, BK_RUN} bk_state_t;

  bk_state_t        state_r, state_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [7:0]       oseq_r, oseq_nxt;
  logic [4:0]       idx_r, idx_nxt;
  logic [7:0]       pb_r, pb_nxt;
  logic             last_r, last_nxt;
  logic             ofree, is_last;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       mem_q_r;

  assign ofree   = !ov_r || out_ready;
  assign is_last = ((k_r + LEN_W'(1)) == len_r);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    ov_nxt    = ov_r && !out_ready;
    st_nxt    = st_r;
    oseq_nxt  = oseq_r;
    idx_nxt   = idx_r;
    pb_nxt    = pb_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    run_done  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = k_r[AW-1:0];
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && q_job.run) begin
          pop       = 1'b1;
          seq_nxt   = q_job.seq;
          len_nxt   = q_job.len;
          k_nxt     = '0;
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = BK_RUN;
        end else if (q_valid && ofree) begin
          pop      = 1'b1;
          ov_nxt   = 1'b1;
          st_nxt   = q_job.status;
          oseq_nxt = q_job.seq;
          idx_nxt  = '0;
          pb_nxt   = '0;
          last_nxt = 1'b1;
        end
      end
      BK_RUN: begin
        if (ofree) begin
          ov_nxt   = 1'b1;
          st_nxt   = ST_ACCEPTED;
          oseq_nxt = seq_r;
          idx_nxt  = k_r[4:0];
          pb_nxt   = mem_q_r;
          last_nxt = is_last;
          if (is_last) begin
            run_done  = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            k_nxt   = k_r + LEN_W'(1);
            rd_en   = 1'b1;
            rd_addr = k_nxt[AW-1:0];
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    k_r    <= k_nxt;
    len_r  <= len_nxt;
    seq_r  <= seq_nxt;
    st_r   <= st_nxt;
    oseq_r <= oseq_nxt;
    idx_r  <= idx_nxt;
    pb_r   <= pb_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_frame_status = st_r;
  assign out_sequence_res = oseq_r;
  assign out_byte_index   = idx_r;
  assign out_payload_byte = pb_r;
  assign out_run_last     = last_r;

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_RUN |-> k_r < len_r) else $error("run index beyond frame length");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    run_done |=> (out_valid && out_run_last)) else $error("run finished without a last transfer");

endmodule

>>> hdl/sync_framed_packet_deframer_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake           | Payload
// in_      | in_valid/in_ready   | in_byte
// out_     | out_valid/out_ready | frame_status, sequence_res, byte_index,
//          |                     | payload_byte, run_last
// cfg_     | cfg_we              | cfg_index, cfg_data
//
// One input byte is taken per cycle while in_ready is high; each result is registered in the output stage.
// The output stage reads each payload run back from the payload store.
// Payload bytes of the next frame wait while the previous run is still queued or draining.
// A two-entry job queue sits between the parser and the output stage.
// Reset is synchronous, active low; the payload store is not cleared.
module sync_framed_packet_deframer_top import sfpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_frame_status,
  output logic [7:0] out_sequence_res,
  output logic [4:0] out_byte_index,
  output logic [7:0] out_payload_byte,
  output logic       out_run_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic          q_full, push, pop, q_valid, run_done;
  job_t          push_job, q_job;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  sfpd_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_byte,
    .q_full, .push, .push_job, .run_done,
    .wr_en, .wr_addr, .wr_data
  );

  sfpd_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full),
    .pop, .q_valid, .q_job
  );

  sfpd_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_back (
    .clk, .rst_n, .q_valid, .q_job, .pop, .run_done,
    .wr_en, .wr_addr, .wr_data,
    .out_valid, .out_ready, .out_frame_status, .out_sequence_res,
    .out_byte_index, .out_payload_byte, .out_run_last
  );

endmodule
